// ===== hdl/mc_call_delta_gamma_unit_macros.svh =====
// Assertion helpers for the unit's controller.
// Both macros expect clk_i and rst_ni to be visible where they are used.
`ifndef MC_CALL_DELTA_GAMMA_UNIT_MACROS_SVH
`define MC_CALL_DELTA_GAMMA_UNIT_MACROS_SVH

// Same-cycle implication.
`define MCDG_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mcdg: same-cycle check failed");

// Next-cycle implication.
`define MCDG_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mcdg: next-cycle check failed");

`endif

// ===== hdl/mcdg_pkg.sv =====
package mcdg_pkg;

  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned ACC_W          = 80;
  localparam int unsigned CFG_IDX_W      = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_UP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_MID     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_DOWN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_ROOT_TIME   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT_FACTOR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_BUMP    = 3'd6;

  // Lanes of the three bumped paths.
  localparam logic [1:0] LANE_UP   = 2'd0;
  localparam logic [1:0] LANE_MID  = 2'd1;
  localparam logic [1:0] LANE_DOWN = 2'd2;

  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [31:0] LN2_Q30   = 32'd744261118;
  localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
  localparam logic [3:0]  HORNER_K0 = 4'd9;
  localparam logic [6:0]  DIV_STEPS = 7'd64;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_MUL_XG,
    OP_MUL_Y,
    OP_SPLIT,
    OP_MUL_T,
    OP_H_INIT,
    OP_H_TP,
    OP_H_RECIP,
    OP_H_UPD,
    OP_EXP_FIN,
    OP_MUL_FWD,
    OP_ACC,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DF_LO,
    OP_DF_HI,
    OP_DF_FIN,
    OP_DELTA_PREP,
    OP_MUL_DELTA,
    OP_DELTA_FIN,
    OP_G_LO,
    OP_G_HI,
    OP_G1_FIN,
    OP_G2_LO,
    OP_G2_HI,
    OP_G2_FIN,
    OP_PUBLISH
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] lane;
  } cmd_t;

  typedef struct packed {
    logic k_last;
    logic div_last;
    logic last;
  } status_t;

  typedef struct packed {
    logic signed [15:0] normal_sample;
    logic               last_sample;
  } in_beat_t;

  typedef struct packed {
    logic [31:0]        price_up;
    logic [31:0]        price_mid;
    logic [31:0]        price_down;
    logic signed [31:0] delta_estimate;
    logic signed [31:0] gamma_estimate;
  } out_beat_t;

  // floor(2^32 / k) for the Horner divisors; k of one is handled apart.
  function automatic logic [31:0] recip_k(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870912;
      4'd9:    r = 32'd477218588;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Sign and magnitude to saturated 32-bit two's complement.
  function automatic logic [31:0] to_s32(input logic neg, input logic [63:0] mag);
    logic [31:0] r;
    if (mag >= 64'h0000_0000_8000_0000) begin
      r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = neg ? (32'd0 - mag[31:0]) : mag[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/mc_call_delta_gamma_unit.sv =====
// Monte Carlo European call pricer with finite-difference delta and gamma. Each input beat
// carries one standard normal draw (signed Q3.12) and a flag that marks the last draw of a
// run. The unit forms exp(vol_root_time * g) in saturating Q16.16, scales it by the up, mid
// and down forwards and adds each call payoff into a saturating 64-bit sum. The beat that
// carries the last flag also closes the run: each sum is divided by the sample count,
// discounted, and one output beat carries the three prices together with delta and gamma,
// after which the sums and the count restart from zero. Everything runs through one shared
// 32x32 multiplier, so the unit works on one draw at a time: an ordinary draw runs the
// exponential as a nine-step Horner evaluation, each step a multiply, a reciprocal
// multiply and an update, and the work that closes a run is mostly the three 64-step
// bit-serial divisions by the sample count. The result sits in an output register, so
// the next draw is taken while it waits; only the following run's result waits for it to
// drain. Configuration writes are always ready and must be issued while the unit is idle.
module mc_call_delta_gamma_unit
  import mcdg_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_beat_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_beat_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  // Register writes complete in the cycle they are offered.
  assign cfg_ready_o = 1'b1;

  mcdg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // The datapath captures the draw on the same edge the controller accepts it.
  mcdg_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .load_i      (in_valid_i && in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/mcdg_datapath.sv =====
module mcdg_datapath
  import mcdg_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic                 load_i,
  input  in_beat_t             in_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output out_beat_t            out_data_o
);

  // Configuration.
  logic [31:0] fwd_q [3];
  logic [31:0] strike_q, inv_q;
  logic [15:0] vrt_q, df_q;

  // Sample and exponential.
  logic signed [15:0] g_q;
  logic               last_q;
  logic [7:0]         n_q;
  logic [29:0]        f_q, t_q;
  logic [31:0]        p_q, a_q, e_q;
  logic [3:0]         k_q;

  // Shared multiplier and partial-product accumulator.
  logic [31:0]      mul_a, mul_b;
  logic             mul_en;
  logic [63:0]      prod_q;
  logic [ACC_W-1:0] acc_q, tot;

  // Running sums and divider.
  logic [63:0]           sum_q [3];
  logic [COUNT_BITS-1:0] count_q, rem_q;
  logic [63:0]           quo_q;
  logic [6:0]            div_cnt_q;
  logic [COUNT_BITS:0]   trial;
  logic                  trial_ge;

  // Finishing and Greeks.
  logic [31:0]        price_q [3];
  logic               dneg_q, gneg_q;
  logic [31:0]        dmag_q;
  logic [33:0]        gmag_q;
  logic [43:0]        r1_q;
  logic [31:0]        delta_q, gamma_q;
  out_beat_t          res_q;

  logic [15:0] g_mag;
  logic [63:0] y_sig;
  logic [7:0]  exp_sh;
  logic [31:0] e_d;
  logic [31:0] q0, q_d;
  logic [35:0] rk;
  logic [47:0] price_w, diff_w;
  logic [64:0] sum_w;
  logic [63:0] d_w;
  logic [53:0] r1_w;
  logic [34:0] s_w;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd_i.op)
      OP_MUL_XG:   begin mul_a = 32'(vrt_q);         mul_b = 32'(g_mag);      end
      OP_MUL_Y:    begin mul_a = prod_q[31:0];       mul_b = LOG2E_Q30;       end
      OP_MUL_T:    begin mul_a = 32'(f_q);           mul_b = LN2_Q30;         end
      OP_H_TP:     begin mul_a = 32'(t_q);           mul_b = p_q;             end
      OP_H_RECIP:  begin mul_a = prod_q[61:30];      mul_b = recip_k(k_q);    end
      OP_MUL_FWD:  begin mul_a = fwd_q[cmd_i.lane];  mul_b = e_q;             end
      OP_DF_LO:    begin mul_a = quo_q[31:0];        mul_b = 32'(df_q);       end
      OP_DF_HI:    begin mul_a = quo_q[63:32];       mul_b = 32'(df_q);       end
      OP_MUL_DELTA: begin mul_a = dmag_q;            mul_b = inv_q;           end
      OP_G_LO:     begin mul_a = gmag_q[31:0];       mul_b = inv_q;           end
      OP_G_HI:     begin mul_a = 32'(gmag_q[33:32]); mul_b = inv_q;           end
      OP_G2_LO:    begin mul_a = r1_q[31:0];         mul_b = inv_q;           end
      OP_G2_HI:    begin mul_a = 32'(r1_q[43:32]);   mul_b = inv_q;           end
      default:     mul_en = 1'b0;
    endcase
  end

  always_comb begin
    g_mag  = g_q[15] ? (16'd0 - g_q) : g_q;
    y_sig  = g_q[15] ? (64'd0 - prod_q) : prod_q;
    exp_sh = 8'd14 - n_q;
    if ($signed(n_q) >= 8'sd16) begin
      e_d = '1;
    end else if ($signed(n_q) >= 8'sd14) begin
      e_d = n_q[0] ? {p_q[30:0], 1'b0} : p_q;
    end else if (exp_sh >= 8'd32) begin
      e_d = '0;
    end else begin
      e_d = p_q >> exp_sh[4:0];
    end
    // Reciprocal quotient is low by at most one; one compare fixes it.
    q0 = prod_q[63:32];
    rk = 36'(a_q) - (36'(q0) * 36'(k_q));
    if (k_q == 4'd1) begin
      q_d = a_q;
    end else begin
      q_d = (rk >= 36'(k_q)) ? (q0 + 32'd1) : q0;
    end
    price_w  = prod_q[63:16];
    diff_w   = price_w - 48'(strike_q);
    sum_w    = {1'b0, sum_q[cmd_i.lane]} + 65'(diff_w);
    trial    = {rem_q, quo_q[63]};
    trial_ge = trial >= {1'b0, count_q};
    tot      = acc_q + {prod_q[47:0], 32'd0};
    d_w      = tot[79:16];
    r1_w     = tot[65:12];
    s_w      = {3'b0, price_q[LANE_UP]} + {3'b0, price_q[LANE_DOWN]}
             - {2'b0, price_q[LANE_MID], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= 64'(mul_a) * 64'(mul_b);
    end
    if (load_i) begin
      g_q    <= in_data_i.normal_sample;
      last_q <= in_data_i.last_sample;
    end
    case (cmd_i.op)
      OP_SPLIT: begin
        n_q <= y_sig[63:56];
        f_q <= y_sig[55:26];
      end
      OP_H_INIT: begin
        t_q <= prod_q[59:30];
        p_q <= Q30_ONE;
        k_q <= HORNER_K0;
      end
      OP_H_RECIP: a_q <= prod_q[61:30];
      OP_H_UPD: begin
        p_q <= Q30_ONE + q_d;
        k_q <= k_q - 4'd1;
      end
      OP_EXP_FIN: e_q <= e_d;
      OP_DIV_INIT: begin
        rem_q     <= '0;
        quo_q     <= sum_q[cmd_i.lane];
        div_cnt_q <= DIV_STEPS;
      end
      OP_DIV_STEP: begin
        rem_q     <= trial_ge ? COUNT_BITS'(trial - {1'b0, count_q})
                              : trial[COUNT_BITS-1:0];
        quo_q     <= {quo_q[62:0], trial_ge};
        div_cnt_q <= div_cnt_q - 7'd1;
      end
      OP_DF_HI, OP_G_HI, OP_G2_HI: acc_q <= ACC_W'(prod_q);
      OP_DF_FIN: price_q[cmd_i.lane] <= (|d_w[63:32]) ? 32'hFFFF_FFFF : d_w[31:0];
      OP_DELTA_PREP: begin
        dneg_q <= price_q[LANE_UP] < price_q[LANE_MID];
        dmag_q <= (price_q[LANE_UP] < price_q[LANE_MID])
                ? (price_q[LANE_MID] - price_q[LANE_UP])
                : (price_q[LANE_UP] - price_q[LANE_MID]);
        gneg_q <= s_w[34];
        gmag_q <= s_w[34] ? 34'(35'd0 - s_w) : s_w[33:0];
      end
      OP_DELTA_FIN: delta_q <= to_s32(dneg_q, 64'(prod_q[63:12]));
      OP_G1_FIN: r1_q <= (|r1_w[53:44]) ? '1 : r1_w[43:0];
      OP_G2_FIN: gamma_q <= to_s32(gneg_q, tot[75:12]);
      OP_PUBLISH: begin
        res_q.price_up       <= price_q[LANE_UP];
        res_q.price_mid      <= price_q[LANE_MID];
        res_q.price_down     <= price_q[LANE_DOWN];
        res_q.delta_estimate <= delta_q;
        res_q.gamma_estimate <= gamma_q;
      end
      default: ;
    endcase
  end

  // Sums, count and configuration carry reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '{default: '0};
      count_q  <= '0;
      fwd_q    <= '{default: '0};
      strike_q <= '0;
      vrt_q    <= '0;
      df_q     <= 16'hFFFF;
      inv_q    <= 32'd4096;
    end else begin
      if (cmd_i.op == OP_ACC) begin
        if (price_w > 48'(strike_q)) begin
          sum_q[cmd_i.lane] <= sum_w[64] ? '1 : sum_w[63:0];
        end
        if (cmd_i.lane == LANE_DOWN && count_q != '1) begin
          count_q <= count_q + 1'b1;
        end
      end else if (cmd_i.op == OP_PUBLISH) begin
        sum_q   <= '{default: '0};
        count_q <= '0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FORWARD_UP:      fwd_q[LANE_UP]   <= cfg_data_i;
          REG_FORWARD_MID:     fwd_q[LANE_MID]  <= cfg_data_i;
          REG_FORWARD_DOWN:    fwd_q[LANE_DOWN] <= cfg_data_i;
          REG_STRIKE:          strike_q         <= cfg_data_i;
          REG_VOL_ROOT_TIME:   vrt_q            <= cfg_data_i[15:0];
          REG_DISCOUNT_FACTOR: df_q             <= cfg_data_i[15:0];
          REG_INVERSE_BUMP:    inv_q            <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign status_o.k_last   = (k_q == 4'd1);
  assign status_o.div_last = (div_cnt_q == 7'd1);
  assign status_o.last     = last_q;
  assign out_data_o        = res_q;

endmodule

// ===== hdl/mcdg_ctrl.sv =====
`include "mc_call_delta_gamma_unit_macros.svh"

module mcdg_ctrl
  import mcdg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output cmd_t    cmd_o,
  input  status_t status_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  state_e state_q;
  cmd_t   cmd_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '{op: OP_NOP, lane: LANE_UP};
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          cmd_q.op <= OP_NOP;
          if (in_valid_i) begin
            state_q  <= ST_RUN;
            cmd_q.op <= OP_MUL_XG;
          end
        end
        ST_HOLD: begin
          // The result register must be empty, or emptied now, before it is rewritten.
          if (!out_valid_q || out_ready_i) begin
            state_q  <= ST_RUN;
            cmd_q.op <= OP_PUBLISH;
          end
        end
        ST_RUN: begin
          case (cmd_q.op)
            OP_MUL_XG:  cmd_q.op <= OP_MUL_Y;
            OP_MUL_Y:   cmd_q.op <= OP_SPLIT;
            OP_SPLIT:   cmd_q.op <= OP_MUL_T;
            OP_MUL_T:   cmd_q.op <= OP_H_INIT;
            OP_H_INIT:  cmd_q.op <= OP_H_TP;
            OP_H_TP:    cmd_q.op <= OP_H_RECIP;
            OP_H_RECIP: cmd_q.op <= OP_H_UPD;
            OP_H_UPD:   cmd_q.op <= status_i.k_last ? OP_EXP_FIN : OP_H_TP;
            OP_EXP_FIN: cmd_q <= '{op: OP_MUL_FWD, lane: LANE_UP};
            OP_MUL_FWD: cmd_q.op <= OP_ACC;
            OP_ACC: begin
              if (cmd_q.lane != LANE_DOWN) begin
                cmd_q <= '{op: OP_MUL_FWD, lane: cmd_q.lane + 2'd1};
              end else if (status_i.last) begin
                cmd_q <= '{op: OP_DIV_INIT, lane: LANE_UP};
              end else begin
                state_q  <= ST_IDLE;
                cmd_q.op <= OP_NOP;
              end
            end
            OP_DIV_INIT: cmd_q.op <= OP_DIV_STEP;
            OP_DIV_STEP: cmd_q.op <= status_i.div_last ? OP_DF_LO : OP_DIV_STEP;
            OP_DF_LO:    cmd_q.op <= OP_DF_HI;
            OP_DF_HI:    cmd_q.op <= OP_DF_FIN;
            OP_DF_FIN: begin
              if (cmd_q.lane != LANE_DOWN) begin
                cmd_q <= '{op: OP_DIV_INIT, lane: cmd_q.lane + 2'd1};
              end else begin
                cmd_q.op <= OP_DELTA_PREP;
              end
            end
            OP_DELTA_PREP: cmd_q.op <= OP_MUL_DELTA;
            OP_MUL_DELTA:  cmd_q.op <= OP_DELTA_FIN;
            OP_DELTA_FIN:  cmd_q.op <= OP_G_LO;
            OP_G_LO:       cmd_q.op <= OP_G_HI;
            OP_G_HI:       cmd_q.op <= OP_G1_FIN;
            OP_G1_FIN:     cmd_q.op <= OP_G2_LO;
            OP_G2_LO:      cmd_q.op <= OP_G2_HI;
            OP_G2_HI:      cmd_q.op <= OP_G2_FIN;
            OP_G2_FIN: begin
              state_q  <= ST_HOLD;
              cmd_q.op <= OP_NOP;
            end
            OP_PUBLISH: begin
              state_q     <= ST_IDLE;
              cmd_q.op    <= OP_NOP;
              out_valid_q <= 1'b1;
            end
            default: begin
              state_q  <= ST_IDLE;
              cmd_q.op <= OP_NOP;
            end
          endcase
        end
        default: begin
          state_q  <= ST_IDLE;
          cmd_q.op <= OP_NOP;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd_q;

  `MCDG_ASSERT_NXT(a_accept_starts, in_valid_i && in_ready_o, cmd_q.op == OP_MUL_XG)
  `MCDG_ASSERT_IMP(a_publish_free, cmd_q.op == OP_PUBLISH, !out_valid_q)
  `MCDG_ASSERT_IMP(a_valid_from_publish, $rose(out_valid_q), $past(cmd_q.op == OP_PUBLISH))

endmodule

// ===== tb/sv/mc_call_delta_gamma_unit_checker.sv =====
module mc_call_delta_gamma_unit_checker
  import mcdg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_beat_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_beat_t            out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] fwd_up, fwd_mid, fwd_down, strike_q16, inv_bump;
  logic [15:0] vol_q14, disc_q16;
  logic [63:0] sum_up, sum_mid, sum_down, draws;
  out_beat_t   price_q[$];

  // Exponential of vol_root_time*g as saturating Q16.16, via 2^(x*log2 e).
  function automatic logic [63:0] growth_q16(input logic [15:0] v, input logic signed [15:0] g);
    logic signed [63:0] x;
    logic [63:0] u, f, t, p;
    int n;
    x = $signed({48'd0, v}) * 64'(g);
    u = 64'(x) * 64'(LOG2E_Q30) + (64'd1 << 62);
    n = int'(u[63:56]) - 64;
    f = (u & ((64'd1 << 56) - 1)) >> 26;
    t = (f * 64'(LN2_Q30)) >> 30;
    p = 64'd1 << 30;
    for (int k = 9; k >= 1; k--) begin
      p = (64'd1 << 30) + ((t * p) >> 30) / 64'(k);
    end
    if (n >= 16) return 64'hFFFF_FFFF;
    if (n >= 14) return p << (n - 14);
    if (14 - n >= 32) return 64'd0;
    return p >> (14 - n);
  endfunction

  function automatic logic [63:0] add_payoff(input logic [63:0] sum, input logic [31:0] fwd,
                                             input logic [63:0] e);
    logic [63:0] price, s;
    price = (64'(fwd) * e) >> 16;
    if (price <= 64'(strike_q16)) return sum;
    s = sum + (price - 64'(strike_q16));
    return (s < sum) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
  endfunction

  function automatic logic [31:0] discounted_mean(input logic [63:0] sum);
    logic [63:0] mean, d;
    mean = sum / draws;
    d = (mean >> 16) * 64'(disc_q16) + (((mean & 64'hFFFF) * 64'(disc_q16)) >> 16);
    return (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
  endfunction

  // Multiply by 1/bump in Q20.12; all ones stands for a product past 64 bits.
  function automatic logic [63:0] bump_scale(input logic [63:0] m);
    if (m == 64'hFFFF_FFFF_FFFF_FFFF && inv_bump != 0) return m;
    if (inv_bump != 0 && m > 64'hFFFF_FFFF_FFFF_FFFF / 64'(inv_bump))
      return 64'hFFFF_FFFF_FFFF_FFFF;
    return (m * 64'(inv_bump)) >> 12;
  endfunction

  function automatic logic [31:0] clamp_s32(input logic neg, input logic [63:0] mag);
    if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  function automatic out_beat_t close_run();
    out_beat_t r;
    logic signed [63:0] s;
    logic [63:0] m;
    logic neg;
    r.price_up   = discounted_mean(sum_up);
    r.price_mid  = discounted_mean(sum_mid);
    r.price_down = discounted_mean(sum_down);
    neg = r.price_up < r.price_mid;
    m = neg ? 64'(r.price_mid - r.price_up) : 64'(r.price_up - r.price_mid);
    r.delta_estimate = clamp_s32(neg, bump_scale(m));
    s = $signed(64'(r.price_up)) + $signed(64'(r.price_down)) - 2 * $signed(64'(r.price_mid));
    neg = s < 0;
    m = neg ? 64'(-s) : 64'(s);
    // A first scaling that overflows must not be rescaled into a small value.
    m = bump_scale(m);
    if (m != 64'hFFFF_FFFF_FFFF_FFFF) m = bump_scale(m);
    r.gamma_estimate = clamp_s32(neg, m);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] e;
    out_beat_t want;
    if (!rst_ni) begin
      fwd_up <= '0; fwd_mid <= '0; fwd_down <= '0; strike_q16 <= '0;
      vol_q14 <= '0; disc_q16 <= 16'd65535; inv_bump <= 32'd4096;
      sum_up = '0; sum_mid = '0; sum_down = '0; draws = '0;
      price_q.delete();
      errors_o = 0; checked_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_FORWARD_UP:      fwd_up     <= cfg_data_i;
          REG_FORWARD_MID:     fwd_mid    <= cfg_data_i;
          REG_FORWARD_DOWN:    fwd_down   <= cfg_data_i;
          REG_STRIKE:          strike_q16 <= cfg_data_i;
          REG_VOL_ROOT_TIME:   vol_q14    <= cfg_data_i[15:0];
          REG_DISCOUNT_FACTOR: disc_q16   <= cfg_data_i[15:0];
          REG_INVERSE_BUMP:    inv_bump   <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        e = growth_q16(vol_q14, in_data_i.normal_sample);
        sum_up   = add_payoff(sum_up, fwd_up, e);
        sum_mid  = add_payoff(sum_mid, fwd_mid, e);
        sum_down = add_payoff(sum_down, fwd_down, e);
        if (draws < 64'hFFFF_FFFF) draws = draws + 1;
        if (in_data_i.last_sample) begin
          price_q.push_back(close_run());
          sum_up = '0; sum_mid = '0; sum_down = '0; draws = '0;
        end
      end
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (price_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result beat %h", $realtime, out_data_i);
        end else begin
          want = price_q.pop_front();
          if (want.price_up !== out_data_i.price_up) begin
            errors_o++;
            $display("%0t: price_up expected %h got %h", $realtime, want.price_up,
                     out_data_i.price_up);
          end
          if (want.price_mid !== out_data_i.price_mid) begin
            errors_o++;
            $display("%0t: price_mid expected %h got %h", $realtime, want.price_mid,
                     out_data_i.price_mid);
          end
          if (want.price_down !== out_data_i.price_down) begin
            errors_o++;
            $display("%0t: price_down expected %h got %h", $realtime, want.price_down,
                     out_data_i.price_down);
          end
          if (want.delta_estimate !== out_data_i.delta_estimate) begin
            errors_o++;
            $display("%0t: delta expected %h got %h", $realtime, want.delta_estimate,
                     out_data_i.delta_estimate);
          end
          if (want.gamma_estimate !== out_data_i.gamma_estimate) begin
            errors_o++;
            $display("%0t: gamma expected %h got %h", $realtime, want.gamma_estimate,
                     out_data_i.gamma_estimate);
          end
        end
      end
    end
    pending_o = price_q.size();
  end

endmodule

// ===== tb/sv/mc_call_delta_gamma_unit_tb.sv =====
// Top of the testbench. It builds the clock and reset, drives draws and register
// writes into the unit, and leaves all prediction and comparison to the checker.
module mc_call_delta_gamma_unit_tb;
  import mcdg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_beat_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_beat_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i  = '0;

  int errors, pending, checked;
  int draws_sent, runs_sent, settings_used;
  int burst_left;
  // The long receiver hold-off is requested by the stimulus and served by the receiver.
  logic hold_go = 1'b0, hold_done = 1'b0;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  mc_call_delta_gamma_unit i_dut (.*);

  mc_call_delta_gamma_unit_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .checked_o(checked)
  );

  // Even if every draw closed a run, the whole stimulus would need about 4 ms, so 20 ms
  // leaves a wide margin.
  initial begin
    #20ms;
    $display("mc_call_delta_gamma_unit_tb: done, errors");
    $finish;
  end

  // The receiver switches between patterns of random length: always ready, a coin flip
  // per cycle, and mostly stalled. Once it is asked, it holds off for a long stretch so
  // that the result register fills and the unit stops taking draws.
  initial begin
    int mode, span;
    @(posedge rst_ni);
    forever begin
      if (hold_go && !hold_done) begin
        @(posedge clk_i);
        out_ready_i <= 1'b0;
        repeat (1999) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(20, 150);
        repeat (span) begin
          @(posedge clk_i);
          case (mode)
            0:       out_ready_i <= 1'b1;
            1:       out_ready_i <= 1'($urandom_range(0, 1));
            default: out_ready_i <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // One draw beat. Draws go out in bursts; between bursts the sender drops valid for a
  // random gap, and now and then a burst runs long.
  task automatic send_draw(input logic signed [15:0] g, input logic last);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{normal_sample: g, last_sample: last};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    draws_sent++;
    if (last) runs_sent++;
  endtask

  // Mostly bell-shaped draws within about three sigma, the rest uniform over all codes.
  function automatic logic signed [15:0] pick_draw();
    if ($urandom_range(0, 3) != 0)
      return 16'($urandom_range(0, 8192) + $urandom_range(0, 8192) + $urandom_range(0, 8192)
                 - 12288);
    return 16'($urandom);
  endfunction

  task automatic send_run(input int len);
    for (int i = 1; i <= len; i++) send_draw(pick_draw(), i == len);
  endtask

  // Stop sending and wait until every result is back, then idle before returning.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [31:0] up, mid, down, strike,
                           input logic [15:0] vol, disc, input logic [31:0] inv);
    write_reg(REG_FORWARD_UP, up);
    write_reg(REG_FORWARD_MID, mid);
    write_reg(REG_FORWARD_DOWN, down);
    write_reg(REG_STRIKE, strike);
    write_reg(REG_VOL_ROOT_TIME, {16'($urandom), vol});
    write_reg(REG_DISCOUNT_FACTOR, {16'($urandom), disc});
    write_reg(REG_INVERSE_BUMP, inv);
    settings_used++;
  endtask

  // Either a market-like setting around a random spot, or raw random register values.
  task automatic configure_random();
    logic [31:0] mid, bump;
    if ($urandom_range(0, 3) == 0) begin
      configure($urandom, $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                $urandom);
    end else begin
      mid  = ($urandom_range(1, 400) << 16) | $urandom_range(0, 65535);
      bump = $urandom_range(0, mid >> 3);
      configure(mid + bump, mid, mid - bump, mid + $urandom_range(0, mid >> 2) - (mid >> 3),
                16'($urandom_range(0, 16384)), 16'($urandom_range(45000, 65535)),
                $urandom_range(0, 1 << 20));
    end
  endtask

  initial begin
    int goal;
    burst_left = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero forwards, so every payoff is zero.
    send_draw(16'sd0, 1'b0);
    send_draw(16'sd4096, 1'b1);
    drain();

    // A market-like setting: spot 100, strike 100, sigma*sqrt(T) 0.2, bump 1.
    configure(32'd101 << 16, 32'd100 << 16, 32'd99 << 16, 32'd100 << 16,
              16'd3277, 16'd62259, 32'd4096);
    send_draw(16'sd32767, 1'b1);
    send_draw(-16'sd32768, 1'b1);
    send_draw(16'sd0, 1'b0);
    send_draw(16'sd1, 1'b0);
    send_draw(-16'sd1, 1'b1);
    send_draw(16'sd8192, 1'b0);
    send_draw(-16'sd4096, 1'b1);
    drain();

    // All at the top but the mid forward: the exponential, the up and down prices and
    // both greeks saturate, and the most negative draw drives the exponential to zero.
    configure(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 16'hFFFF,
              32'hFFFF_FFFF);
    send_draw(16'sd32767, 1'b1);
    send_draw(-16'sd32768, 1'b1);
    send_draw(16'sd32767, 1'b0);
    send_draw(16'sd2000, 1'b1);
    drain();

    // Unit growth, zero inverse bump and discount factor, and a strike no price can beat.
    configure(32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 16'd0, 16'd0, 32'd0);
    send_draw(16'sd12345, 1'b1);
    send_draw(-16'sd32768, 1'b0);
    send_draw(16'sd32767, 1'b1);
    drain();

    // Deep-in-the-money, mid forward far above the others: delta goes negative and large.
    configure(32'd1 << 16, 32'hFFFF_0000, 32'd2 << 16, 32'd0, 16'd16384, 16'd65535,
              32'h0100_0000);
    send_draw(16'sd0, 1'b1);
    send_draw(16'sd4096, 1'b0);
    send_draw(-16'sd4096, 1'b1);
    drain();

    // Random part: one setting per phase, draws in runs that are mostly short. In one
    // phase the receiver holds off while runs of one or two draws keep coming, so the
    // unit fills up and stalls its input.
    for (int phase = 0; phase < 10; phase++) begin
      configure_random();
      if (phase == 4) begin
        hold_go = 1'b1;
        for (int r = 0; r < 14; r++) send_run($urandom_range(1, 2));
      end
      goal = draws_sent + 130;
      while (draws_sent < goal) begin
        send_run(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8));
      end
      drain();
    end

    $display("Sent %0d draws in %0d runs under %0d register settings; %0d results checked.",
             draws_sent, runs_sent, settings_used, checked);
    if (errors == 0) begin
      $display("mc_call_delta_gamma_unit_tb: done, clean");
    end else begin
      $display("mc_call_delta_gamma_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== mc_call_delta_gamma_unit.f =====
+incdir+hdl
hdl/mcdg_pkg.sv
hdl/mcdg_datapath.sv
hdl/mcdg_ctrl.sv
hdl/mc_call_delta_gamma_unit.sv
tb/sv/mc_call_delta_gamma_unit_checker.sv
tb/sv/mc_call_delta_gamma_unit_tb.sv
